@@ design/wav_pkg.sv @@
// Package for the WAV PCM16 stream writer: payload structs, codes, header table.
// Used by the top level, wav_front and wav_back; no dependencies.
`default_nettype none
package wav_pkg;

    localparam int unsigned RateReset   = 24000;
    localparam int unsigned QueueDepth  = 4;
    localparam int unsigned HeaderBytes = 44;

    localparam logic       ModeStart  = 1'b0;
    localparam logic       ModeSample = 1'b1;
    localparam logic [0:0] RegRate    = 1'b0;
    localparam logic [0:0] RegCount   = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [31:0] sample_bits;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       file_end;
    } t_out_item;

    // Classified job handed from front to back.
    typedef struct packed {
        logic        is_header;
        logic [15:0] pcm;
        logic [30:0] rate;
        logic [31:0] data_size;
        logic        fend;
    } t_job;

    // Header byte at position idx, for given rate and data size.
    function automatic logic [7:0] header_byte(input logic [5:0] idx,
                                               input logic [30:0] rate,
                                               input logic [31:0] data);
        logic [31:0] riff;
        logic [31:0] rate32;
        logic [31:0] brate;
        logic [7:0]  b;
        riff   = data + 32'd36;
        rate32 = {1'b0, rate};
        brate  = {rate, 1'b0};
        case (idx)
            6'd0:  b = "R";
            6'd1:  b = "I";
            6'd2:  b = "F";
            6'd3:  b = "F";
            6'd4:  b = riff[7:0];
            6'd5:  b = riff[15:8];
            6'd6:  b = riff[23:16];
            6'd7:  b = riff[31:24];
            6'd8:  b = "W";
            6'd9:  b = "A";
            6'd10: b = "V";
            6'd11: b = "E";
            6'd12: b = "f";
            6'd13: b = "m";
            6'd14: b = "t";
            6'd15: b = " ";
            6'd16: b = 8'd16;
            6'd20: b = 8'd1;
            6'd22: b = 8'd1;
            6'd24: b = rate32[7:0];
            6'd25: b = rate32[15:8];
            6'd26: b = rate32[23:16];
            6'd27: b = rate32[31:24];
            6'd28: b = brate[7:0];
            6'd29: b = brate[15:8];
            6'd30: b = brate[23:16];
            6'd31: b = brate[31:24];
            6'd32: b = 8'd2;
            6'd34: b = 8'd16;
            6'd36: b = "d";
            6'd37: b = "a";
            6'd38: b = "t";
            6'd39: b = "a";
            6'd40: b = data[7:0];
            6'd41: b = data[15:8];
            6'd42: b = data[23:16];
            6'd43: b = data[31:24];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

@@ design/wav_pcm16_stream_writer.sv @@
// Top level of the WAV PCM16 stream writer: config registers, front, back.
// Depends on wav_pkg, wav_front, wav_back.
//
// A start request emits the 44-byte mono 16-bit WAV header, one byte per cycle
// while the receiver pops, and clears the sample counter; a sample request
// converts a binary32 value to PCM16 and emits two bytes on the byte-wide result
// port. Requests enter a two-stage front pipeline (clamp/multiply, round) and
// wait in a small job queue; a request's first byte passes both front stages,
// the queue and the output register before it appears. Beyond the configured
// count samples are dropped. Configuration ready stays low while the back end
// holds work; write configuration only while idle.
`default_nettype none
module wav_pcm16_stream_writer #(
    parameter int unsigned QUEUE_DEPTH = wav_pkg::QueueDepth
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire wav_pkg::t_in_item i_item,
    output logic                   empty,
    input  wire logic              pop,
    output wav_pkg::t_out_item     o_item,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [0:0]        i_cfg_index,
    input  wire logic [30:0]       i_cfg_data
);
    logic [30:0] r_rate, r_count;
    logic        job_valid, q_full, busy;
    wav_pkg::t_job job;

    assign o_cfg_ready = !busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate  <= 31'(wav_pkg::RateReset);
            r_count <= 31'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                wav_pkg::RegRate:  r_rate  <= i_cfg_data;
                wav_pkg::RegCount: r_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    wav_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .i_rate     (r_rate),
        .i_count    (r_count),
        .i_q_full   (q_full),
        .o_job_valid(job_valid),
        .o_job      (job)
    );

    wav_back #(.DEPTH(QUEUE_DEPTH)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(job_valid),
        .i_job      (job),
        .o_q_full   (q_full),
        .o_busy     (busy),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_item     (o_item)
    );
endmodule
`default_nettype wire

@@ design/wav_pcm_conv.sv @@
// Two-stage binary32 to PCM16 converter: registered clamp and scale, then a
// combinational round to integer. Pure datapath with an enable; no dependencies.
`default_nettype none
module wav_pcm_conv (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_bits,
    output logic [15:0]      o_pcm
);
    // stage 1: clamp magnitude and multiply mantissa by 32767
    logic        n_sign;
    logic [7:0]  n_exp;
    logic [23:0] n_mant;
    logic [38:0] n_prod;
    logic        r_sign;
    logic [7:0]  r_exp;
    logic [38:0] r_prod;

    always_comb begin
        n_sign = i_bits[31];
        n_exp  = i_bits[30:23];
        n_mant = {1'b1, i_bits[22:0]};
        if (i_bits[30:23] == 8'hff || i_bits[30:23] == 8'h00) begin
            // non-finite and subnormal/zero give zero magnitude
            n_exp  = 8'd0;
            n_mant = 24'd0;
        end else if (i_bits[30:23] >= 8'd127) begin
            // at or above one clamps to one
            n_exp  = 8'd127;
            n_mant = 24'h800000;
        end
        n_prod = n_mant * 39'd32767;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sign <= n_sign;
            r_exp  <= n_exp;
            r_prod <= n_prod;
        end
    end

    // stage 2: round product to binary32 (RNE), then to integer (RNE)
    // value = prod * 2^(exp-127-23); prod has 38 or 39 bits
    logic        top;
    logic [23:0] m24;
    logic        g, st;
    logic [24:0] mr;
    logic [8:0]  e2;
    logic [23:0] m2;
    logic [8:0]  sh;
    logic [47:0] wide;
    logic [15:0] ip;
    logic        fg, fs;
    logic [15:0] mag;
    logic [15:0] n_pcm;

    always_comb begin
        top = r_prod[38];
        if (top) begin
            m24 = r_prod[38:15];
            g   = r_prod[14];
            st  = |r_prod[13:0];
        end else begin
            m24 = r_prod[37:14];
            g   = r_prod[13];
            st  = |r_prod[12:0];
        end
        mr = {1'b0, m24} + {24'd0, g & (st | m24[0])};
        // product float = m2 * 2^(e2 - 23 - 127), e2 biased
        e2 = {1'b0, r_exp} + (top ? 9'd15 : 9'd14);
        m2 = m24;
        if (mr[24]) begin
            m2 = mr[24:1];
            e2 = e2 + 9'd1;
        end else begin
            m2 = mr[23:0];
        end
        // integer part: m2 shifted right by (150 - e2); values < 2^15
        mag = 16'd0;
        if (r_exp != 8'd0 && e2 >= 9'd126) begin
            sh   = 9'd150 - e2;
            wide = {m2, 24'd0} >> sh[4:0];
            ip   = wide[39:24];
            fg   = wide[23];
            fs   = |wide[22:0];
            mag  = ip + {15'd0, fg & (fs | ip[0])};
        end else begin
            sh   = 9'd0;
            wide = 48'd0;
            ip   = 16'd0;
            fg   = 1'b0;
            fs   = 1'b0;
        end
        n_pcm = r_sign ? (16'd0 - mag) : mag;
    end

    assign o_pcm = n_pcm;
endmodule
`default_nettype wire

@@ design/wav_front.sv @@
// Front end: accepts items, keeps the sample counter, drops excess samples,
// converts samples via wav_pcm_conv and pushes classified jobs. Uses wav_pkg.
`default_nettype none
module wav_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire wav_pkg::t_in_item i_item,
    output logic                o_full,
    input  wire logic [30:0]    i_rate,
    input  wire logic [30:0]    i_count,
    input  wire logic           i_q_full,
    output logic                o_job_valid,
    output wav_pkg::t_job       o_job
);
    logic [30:0] r_written;
    logic        r_v1, r_v2;
    wav_pkg::t_job r_j1, r_j2;
    wav_pkg::t_job n_j2;
    logic        adv;
    logic        acc;
    logic        keep;
    logic [15:0] pcm;

    // pipeline moves when its last slot is free or drains into the queue
    assign adv    = !r_v2 || !i_q_full;
    assign o_full = !adv;
    assign acc    = i_push && adv;
    assign keep   = (i_item.mode == wav_pkg::ModeStart) || (r_written < i_count);

    wav_pcm_conv u_conv (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_bits (i_item.sample_bits),
        .o_pcm  (pcm)
    );

    // counter and job classification
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= 31'd0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
        end else if (adv) begin
            r_v1 <= acc && keep;
            r_v2 <= r_v1;
            if (acc && i_item.mode == wav_pkg::ModeStart) begin
                r_written <= 31'd0;
            end else if (acc && keep) begin
                r_written <= r_written + 31'd1;
            end
        end
    end

    // second stage picks up the rounded sample
    always_comb begin
        n_j2 = r_j1;
        if (!r_j1.is_header) begin
            n_j2.pcm = pcm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_j1.is_header <= (i_item.mode == wav_pkg::ModeStart);
            r_j1.pcm       <= 16'd0;
            r_j1.rate      <= i_rate;
            r_j1.data_size <= {i_count, 1'b0};
            r_j1.fend      <= (i_item.mode == wav_pkg::ModeStart) ? (i_count == 31'd0)
                                                   : (r_written + 31'd1 == i_count);
            r_j2 <= n_j2;
        end
    end

    assign o_job_valid = r_v2;
    assign o_job       = r_j2;
endmodule
`default_nettype wire

@@ design/wav_back.sv @@
// Back end: job queue and byte sequencer with output skid register.
// Uses wav_pkg for the job and result types and the header table.
`default_nettype none
module wav_back #(
    parameter int unsigned DEPTH = wav_pkg::QueueDepth
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_valid,
    input  wire wav_pkg::t_job i_job,
    output logic               o_q_full,
    output logic               o_busy,
    output logic               o_empty,
    input  wire logic          i_pop,
    output wav_pkg::t_out_item o_item
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    wav_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic [5:0]    r_idx;
    logic          r_ov;
    wav_pkg::t_out_item r_out;
    logic          q_empty, take, wr, done_job;
    wav_pkg::t_job head;
    wav_pkg::t_out_item n_out;
    logic          last;

    assign o_q_full = (r_cnt == (AW+1)'(DEPTH));
    assign q_empty  = (r_cnt == '0);
    assign head     = r_mem[r_rp];
    assign wr       = i_job_valid && !o_q_full;
    assign take     = !q_empty && (!r_ov || i_pop);
    assign last     = head.is_header ? (r_idx == 6'(wav_pkg::HeaderBytes - 1))
                                     : (r_idx == 6'd1);
    assign done_job = take && last;

    // byte select
    always_comb begin
        if (head.is_header) begin
            n_out.out_byte = wav_pkg::header_byte(r_idx, head.rate, head.data_size);
        end else begin
            n_out.out_byte = r_idx[0] ? head.pcm[15:8] : head.pcm[7:0];
        end
        n_out.run_last = last;
        n_out.file_end = last && head.fend;
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_idx <= 6'd0;
            r_ov  <= 1'b0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (done_job) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(done_job);
            if (take) begin
                r_idx <= last ? 6'd0 : r_idx + 6'd1;
            end
            if (take) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    assign o_empty = !r_ov;
    assign o_item  = r_out;
    assign o_busy  = !q_empty || r_ov;
endmodule
`default_nettype wire

@@ dv/wav_pcm16_stream_writer_tb.sv @@
// Testbench for wav_pcm16_stream_writer: directed table, then random WAV files,
// every output byte checked against an in-bench predictor. Depends on wav_pkg.
`timescale 1ns / 100ps
module wav_pcm16_stream_writer_tb;

    typedef enum logic [1:0] {RowCfg, RowItem} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [0:0]  reg_idx;
        logic [30:0] reg_val;
        logic        mode;
        logic [31:0] bits;
        logic        typed;   // expected PCM given in the table
        logic [15:0] pcm;
    } t_row;

    localparam int unsigned CycleLimit  = 200000;
    localparam int unsigned DrainCycles = 20;
    localparam int unsigned TargetItems = 350;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    wav_pkg::t_in_item    i_item = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    wav_pkg::t_out_item   o_item;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [0:0]           i_cfg_index = wav_pkg::RegRate;
    logic [30:0]          i_cfg_data = '0;

    // Predictor state and expected byte stream
    logic [30:0]          rate_reg;
    logic [30:0]          count_reg;
    logic [30:0]          written_cnt;
    wav_pkg::t_out_item   wav_byte_q[$];

    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned items_sent = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    bit          calm = 1'b0;

    wav_pcm16_stream_writer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_item     (o_item),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("** wav_pcm16_stream_writer: FAILED **");
            $finish;
        end
    end

    // binary32 -> PCM16: clamp, round(x*32767) to float grid, then to integer, RNE
    function automatic logic [15:0] pcm_of_float(input logic [31:0] bits_in);
        logic [31:0]     b;
        int              ex;
        int              x;
        int              len;
        int              d;
        int              k;
        longint unsigned p;
        longint unsigned q;
        longint unsigned rem;
        longint unsigned half;
        logic [15:0]     mag;
        b = bits_in;
        if (b[30:23] == 8'hff) b = '0;
        ex = int'(b[30:23]);
        if (ex >= 127) begin
            mag = 16'd32767;
        end else begin
            p = (ex == 0) ? {41'd0, b[22:0]} : {40'd0, 1'b1, b[22:0]};
            x = ((ex == 0) ? 1 : ex) - 150;
            p = p * 64'd32767;
            if (p == 0) begin
                mag = '0;
            end else begin
                len = 0;
                while ((p >> len) != 0) len++;
                // product back onto the 24-bit significand grid
                if (len > 24) begin
                    d = len - 24;
                    q = p >> d;
                    rem = p & ((64'd1 << d) - 1);
                    half = 64'd1 << (d - 1);
                    if (rem > half || (rem == half && q[0])) q++;
                    p = q;
                    x += d;
                end
                k = -x;
                if (k > 40) begin
                    mag = '0;
                end else if (k <= 0) begin
                    mag = p[15:0];
                end else begin
                    q = p >> k;
                    rem = p & ((64'd1 << k) - 1);
                    half = 64'd1 << (k - 1);
                    if (rem > half || (rem == half && q[0])) q++;
                    mag = q[15:0];
                end
            end
        end
        return b[31] ? -mag : mag;
    endfunction

    // append one expected byte
    function automatic void queue_byte(input wav_pkg::t_out_item b);
        wav_byte_q = {wav_byte_q, b};
    endfunction

    function automatic void queue_header();
        logic [31:0] data;
        logic [31:0] riff;
        logic [31:0] brate;
        logic [7:0]  h[44];
        data = {count_reg, 1'b0};
        riff = data + 32'd36;
        brate = {rate_reg, 1'b0};
        h = '{"R", "I", "F", "F", riff[7:0], riff[15:8], riff[23:16], riff[31:24],
              "W", "A", "V", "E", "f", "m", "t", " ", 8'd16, 8'd0, 8'd0, 8'd0,
              8'd1, 8'd0, 8'd1, 8'd0, rate_reg[7:0], rate_reg[15:8], rate_reg[23:16],
              {1'b0, rate_reg[30:24]}, brate[7:0], brate[15:8], brate[23:16],
              brate[31:24], 8'd2, 8'd0, 8'd16, 8'd0, "d", "a", "t", "a",
              data[7:0], data[15:8], data[23:16], data[31:24]};
        written_cnt = '0;
        for (int i = 0; i < 44; i++)
            queue_byte('{h[i], i == 43, i == 43 && count_reg == 31'd0});
    endfunction

    function automatic void queue_sample(input logic [31:0] bits, input logic typed,
                                         input logic [15:0] typed_pcm);
        logic [15:0] s;
        if (written_cnt >= count_reg) return;  // past N: dropped
        s = typed ? typed_pcm : pcm_of_float(bits);
        written_cnt = written_cnt + 31'd1;
        queue_byte('{s[7:0], 1'b0, 1'b0});
        queue_byte('{s[15:8], 1'b1, written_cnt == count_reg});
    endfunction

    // Register write, only once the block has drained
    task automatic write_reg(input logic [0:0] idx, input logic [30:0] val);
        @(negedge i_clk);
        push = 1'b0;
        while (wav_byte_q.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == wav_pkg::RegRate) rate_reg = val;
        else count_reg = val;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Offer one request; push stays high for a following request
    task automatic send_item(input logic mode, input logic [31:0] bits,
                             input logic typed, input logic [15:0] typed_pcm);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 27) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push = 1'b1;
        i_item = '{mode, bits};
        do @(posedge i_clk); while (full);
        items_sent++;
        if (mode == wav_pkg::ModeStart) queue_header();
        else queue_sample(bits, typed, typed_pcm);
    endtask

    function automatic logic [31:0] rand_float();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 5))
            0: ;
            1, 2: r[30:23] = 8'($urandom_range(110, 126));
            3: r[30:23] = 8'($urandom_range(127, 130));
            4: r[30:23] = 8'hff;
            default: r[30:23] = 8'($urandom_range(0, 109));
        endcase
        return r;
    endfunction

    // Receiver: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            pop = 1'b0;
        end else if (!hold_done && items_sent >= 60) begin
            hold_done = 1'b1;
            hold_left = 300;
            pop = 1'b0;
        end else begin
            pop = calm || ($urandom_range(0, 99) >= 27);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        wav_pkg::t_out_item want;
        if (i_rst_n && !empty && pop) begin
            if (wav_byte_q.size() == 0) begin
                $error("unexpected byte %h", o_item.out_byte);
                errors++;
            end else begin
                want = wav_byte_q.pop_front();
                if (o_item.out_byte !== want.out_byte) begin
                    $error("out_byte expected %h actual %h", want.out_byte, o_item.out_byte);
                    errors++;
                end
                if (o_item.run_last !== want.run_last) begin
                    $error("run_last expected %b actual %b", want.run_last, o_item.run_last);
                    errors++;
                end
                if (o_item.file_end !== want.file_end) begin
                    $error("file_end expected %b actual %b", want.file_end, o_item.file_end);
                    errors++;
                end
            end
        end
    end

    t_row rows[23] = '{
        // sample while N is still 0: dropped
        '{RowItem, wav_pkg::RegRate, 31'd0, wav_pkg::ModeSample, 32'h3f80_0000, 1'b0, 16'd0},
        '{RowCfg, wav_pkg::RegCount, 31'd4, 1'b0, 32'd0, 1'b0, 16'd0},
        '{RowCfg, wav_pkg::RegRate, 31'd1, 1'b0, 32'd0, 1'b0, 16'd0},
        // sample before any start counts from the reset counter
        '{RowItem, wav_pkg::RegRate, 31'd0, wav_pkg::ModeSample, 32'h3f80_0000, 1'b1,
          16'h7fff},
        '{RowItem, wav_pkg::RegRate, 31'd0, wav_pkg::ModeStart, 32'h0000_0000, 1'b0, 16'd0},
        '{RowItem, wav_pkg::RegRate, 31'd0, wav_pkg::ModeSample, 32'h3f80_0000, 1'b1,
          16'h7fff},
        '{RowItem, wav_pkg::RegRate, 31'd0, wav_pkg::ModeSample, 32'hbf80_0000, 1'b1,
          16'h8001},
        '{RowItem, wav_pkg::RegRate, 31'd0, wav_pkg::ModeSample, 32'h7f80_0000, 1'b1,
          16'h0000},
        '{RowItem, wav_pkg::RegRate, 31'd0, wav_pkg::ModeSample, 32'h7fc0_0001, 1'b1,
          16'h0000},
        // excess sample
        '{RowItem, wav_pkg::RegRate, 31'd0, wav_pkg::ModeSample, 32'h4000_0000, 1'b0, 16'd0},
        // extremes: header sizes near the wrap point
        '{RowCfg, wav_pkg::RegRate, 31'h7fff_ffff, 1'b0, 32'd0, 1'b0, 16'd0},
        '{RowCfg, wav_pkg::RegCount, 31'd2147483629, 1'b0, 32'd0, 1'b0, 16'd0},
        '{RowItem, wav_pkg::RegRate, 31'd0, wav_pkg::ModeStart, 32'hffff_ffff, 1'b0, 16'd0},
        '{RowItem, wav_pkg::RegRate, 31'd0, wav_pkg::ModeSample, 32'h3f00_0000, 1'b1,
          16'h4000},
        '{RowItem, wav_pkg::RegRate, 31'd0, wav_pkg::ModeSample, 32'hc000_0000, 1'b1,
          16'h8001},
        '{RowItem, wav_pkg::RegRate, 31'd0, wav_pkg::ModeSample, 32'hffff_ffff, 1'b1,
          16'h0000},
        '{RowItem, wav_pkg::RegRate, 31'd0, wav_pkg::ModeSample, 32'h0000_0001, 1'b1,
          16'h0000},
        '{RowItem, wav_pkg::RegRate, 31'd0, wav_pkg::ModeSample, 32'h8000_0000, 1'b1,
          16'h0000},
        '{RowItem, wav_pkg::RegRate, 31'd0, wav_pkg::ModeSample, 32'h3c00_0123, 1'b0, 16'd0},
        // count lowered mid-stream
        '{RowCfg, wav_pkg::RegCount, 31'd1, 1'b0, 32'd0, 1'b0, 16'd0},
        '{RowItem, wav_pkg::RegRate, 31'd0, wav_pkg::ModeSample, 32'h3e80_0000, 1'b0, 16'd0},
        '{RowCfg, wav_pkg::RegCount, 31'd0, 1'b0, 32'd0, 1'b0, 16'd0},
        '{RowItem, wav_pkg::RegRate, 31'd0, wav_pkg::ModeStart, 32'h0000_0000, 1'b0, 16'd0}
    };

    // Stimulus
    initial begin
        int unsigned n;
        int unsigned extra;
        logic [30:0] val;
        rate_reg = 31'(wav_pkg::RateReset);
        count_reg = '0;
        written_cnt = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) begin
            if (rows[i].kind == RowCfg) write_reg(rows[i].reg_idx, rows[i].reg_val);
            else send_item(rows[i].mode, rows[i].bits, rows[i].typed, rows[i].pcm);
        end

        // Random WAV files
        while (items_sent < TargetItems) begin
            calm = (items_sent > 180 && items_sent < 260);
            case ($urandom_range(0, 5))
                0: val = 31'd1;
                1: val = 31'h7fff_ffff;
                default: val = 31'($urandom);
            endcase
            write_reg(wav_pkg::RegRate, val);
            val = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 14));
            write_reg(wav_pkg::RegCount, val);
            // occasional samples ahead of the start
            repeat ($urandom_range(0, 3) == 0 ? 1 : 0)
                send_item(wav_pkg::ModeSample, rand_float(), 1'b0, 16'd0);
            send_item(wav_pkg::ModeStart, $urandom, 1'b0, 16'd0);
            n = (count_reg > 31'd14) ? 14 : int'(count_reg);
            extra = $urandom_range(0, 2);
            for (int i = 0; i < n + extra; i++)
                send_item(wav_pkg::ModeSample, rand_float(), 1'b0, 16'd0);
            if (count_reg != 31'd0 && $urandom_range(0, 7) == 0) begin
                write_reg(wav_pkg::RegCount, 31'($urandom_range(0, count_reg - 1)));
                repeat ($urandom_range(1, 3))
                    send_item(wav_pkg::ModeSample, rand_float(), 1'b0, 16'd0);
            end
        end

        @(negedge i_clk);
        push = 1'b0;
        while (wav_byte_q.size() != 0) @(negedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0 && wav_byte_q.size() == 0) begin
            $display("** wav_pcm16_stream_writer: PASSED **");
        end else begin
            $display("** wav_pcm16_stream_writer: FAILED **");
        end
        $finish;
    end

endmodule
